// ===== hdl/cau_pkg.sv =====
// Shared constants and types of the Coriolis acceleration unit.
`default_nettype none
package cau_pkg;

  // Field widths of the channels.
  localparam int VEL_W      = 28;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LAT_W      = 24;
  localparam int AZ_W       = 25;
  localparam int ANG_W      = 26;

  // Fixed-point formats.
  localparam int VELOCITY_FRACTION_BITS = 16;
  localparam int TRIG_FRACTION_BITS_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH  = 2'd2;

  // Angle constants in units of 1/65536 degree.
  localparam int FULL_TURN    = 23592960;
  localparam int QUARTER_TURN = 5898240;

  // Degrees (2^-16) to radians (Q30), scaled by 2^24.
  localparam logic [32:0] DEG_TO_RAD_Q = 33'd4797524517;
  // Twice Earth's rotation rate scaled by 2^44.
  localparam logic signed [33:0] TWO_OMEGA_Q = 34'sd2565684875;
  localparam int SERIES_TERMS = 10;

  // Request to the sine and cosine sequencer.
  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } trig_req_t;

  // Status of the sine and cosine sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } trig_stat_t;

endpackage
`default_nettype wire

// ===== hdl/cau_if.sv =====
// Channel interfaces of the Coriolis acceleration unit.
`default_nettype none
interface cau_in_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_downrange;
  logic signed [VEL_W-1:0] vel_up;
  logic signed [VEL_W-1:0] vel_cross;
  modport source (output valid, vel_downrange, vel_up, vel_cross, input ready);
  modport sink (input valid, vel_downrange, vel_up, vel_cross, output ready);
endinterface

interface cau_out_if import cau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] acc_downrange;
  logic signed [ACC_W-1:0] acc_up;
  logic signed [ACC_W-1:0] acc_cross;
  modport source (output valid, acc_downrange, acc_up, acc_cross, input ready);
  modport sink (input valid, acc_downrange, acc_up, acc_cross, output ready);
endinterface

interface cau_cfg_if import cau_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cau_trig.sv =====
// Sequencer that works out the sine and cosine of one angle by a Taylor series.
`default_nettype none
module cau_trig import cau_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  trig_req_t                            req,
  output trig_stat_t                           stat,
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o
);

  localparam int TW  = TRIG_FRACTION_BITS + 2;
  localparam int RSH = 30 - TRIG_FRACTION_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_REDUCE = 4'd1;
  localparam logic [3:0] ST_XMUL   = 4'd2;
  localparam logic [3:0] ST_X2MUL  = 4'd3;
  localparam logic [3:0] ST_SMUL   = 4'd4;
  localparam logic [3:0] ST_SDIV   = 4'd5;
  localparam logic [3:0] ST_CMUL   = 4'd6;
  localparam logic [3:0] ST_CDIV   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;
  localparam logic [3:0] ST_SFIX   = 4'd9;
  localparam logic [3:0] ST_CFIX   = 4'd10;

  localparam logic signed [ANG_W:0] FULL_S = (ANG_W+1)'(FULL_TURN);
  localparam logic [24:0] Q1 = 25'(QUARTER_TURN);
  localparam logic [24:0] Q2 = 25'(2 * QUARTER_TURN);
  localparam logic [24:0] Q3 = 25'(3 * QUARTER_TURN);
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  logic [3:0]              state_r;
  logic signed [ANG_W-1:0] ang_r;
  logic [1:0]              quad_r;
  logic [63:0]             mul_a_r;
  logic [31:0]             mul_b_r;
  logic [63:0]             acc_r;
  logic [31:0]             x2_r;
  logic [31:0]             st_r;
  logic [31:0]             ct_r;
  logic signed [33:0]      ssum_r;
  logic signed [33:0]      csum_r;
  logic [3:0]              k_r;
  logic [31:0]             dvd_r;
  logic [31:0]             qe_r;
  logic                    done_r;

  // Series divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine.
  function automatic logic [8:0] div_sin(input logic [3:0] k);
    case (k)
      4'd1:    div_sin = 9'd6;
      4'd2:    div_sin = 9'd20;
      4'd3:    div_sin = 9'd42;
      4'd4:    div_sin = 9'd72;
      4'd5:    div_sin = 9'd110;
      4'd6:    div_sin = 9'd156;
      4'd7:    div_sin = 9'd210;
      4'd8:    div_sin = 9'd272;
      4'd9:    div_sin = 9'd342;
      4'd10:   div_sin = 9'd420;
      default: div_sin = 9'd1;
    endcase
  endfunction

  function automatic logic [8:0] div_cos(input logic [3:0] k);
    case (k)
      4'd1:    div_cos = 9'd2;
      4'd2:    div_cos = 9'd12;
      4'd3:    div_cos = 9'd30;
      4'd4:    div_cos = 9'd56;
      4'd5:    div_cos = 9'd90;
      4'd6:    div_cos = 9'd132;
      4'd7:    div_cos = 9'd182;
      4'd8:    div_cos = 9'd240;
      4'd9:    div_cos = 9'd306;
      4'd10:   div_cos = 9'd380;
      default: div_cos = 9'd1;
    endcase
  endfunction

  // Reciprocals floor(2^32 / d) of the series divisors.
  function automatic logic [31:0] rcp_sin(input logic [3:0] k);
    case (k)
      4'd1:    rcp_sin = 32'd715827882;
      4'd2:    rcp_sin = 32'd214748364;
      4'd3:    rcp_sin = 32'd102261126;
      4'd4:    rcp_sin = 32'd59652323;
      4'd5:    rcp_sin = 32'd39045157;
      4'd6:    rcp_sin = 32'd27531841;
      4'd7:    rcp_sin = 32'd20452225;
      4'd8:    rcp_sin = 32'd15790320;
      4'd9:    rcp_sin = 32'd12558383;
      4'd10:   rcp_sin = 32'd10226112;
      default: rcp_sin = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] rcp_cos(input logic [3:0] k);
    case (k)
      4'd1:    rcp_cos = 32'd2147483648;
      4'd2:    rcp_cos = 32'd357913941;
      4'd3:    rcp_cos = 32'd143165576;
      4'd4:    rcp_cos = 32'd76695844;
      4'd5:    rcp_cos = 32'd47721858;
      4'd6:    rcp_cos = 32'd32537631;
      4'd7:    rcp_cos = 32'd23598721;
      4'd8:    rcp_cos = 32'd17895697;
      4'd9:    rcp_cos = 32'd14035840;
      4'd10:   rcp_cos = 32'd11302545;
      default: rcp_cos = 32'd0;
    endcase
  endfunction

  // Clamp a Q30 sum to [0, 1] and round it to the trig format.
  function automatic logic signed [TW-1:0] to_trig(input logic signed [33:0] v);
    logic [30:0] c;
    logic [31:0] r;
    if (v < 0) begin
      c = '0;
    end else if (v > 34'sd1073741824) begin
      c = 31'h4000_0000;
    end else begin
      c = v[30:0];
    end
    r = {1'b0, c} + (32'd1 << (RSH - 1));
    to_trig = TW'(r >> RSH);
  endfunction

  // Angle reduction into a quadrant and a rest below a quarter turn.
  logic signed [ANG_W:0] ang_ext;
  logic signed [ANG_W:0] ang_red;
  logic [24:0]           ang_pos;
  logic [1:0]            quad;
  logic [24:0]           frac;

  assign ang_ext = {ang_r[ANG_W-1], ang_r};

  always_comb begin
    if (ang_r < 0) begin
      ang_red = ang_ext + FULL_S;
    end else if (ang_ext >= FULL_S) begin
      ang_red = ang_ext - FULL_S;
    end else begin
      ang_red = ang_ext;
    end
    ang_pos = ang_red[24:0];
    if (ang_pos >= Q3) begin
      quad = 2'd3;
      frac = ang_pos - Q3;
    end else if (ang_pos >= Q2) begin
      quad = 2'd2;
      frac = ang_pos - Q2;
    end else if (ang_pos >= Q1) begin
      quad = 2'd1;
      frac = ang_pos - Q1;
    end else begin
      quad = 2'd0;
      frac = ang_pos;
    end
  end

  // The reciprocal estimate is at most one below the true quotient; one
  // compare against the next multiple of the divisor corrects it.
  logic [8:0]  divisor;
  logic [40:0] next_mult;
  logic        qbit;
  logic [31:0] quo;

  assign divisor   = (state_r == ST_SFIX) ? div_sin(k_r) : div_cos(k_r);
  assign next_mult = 41'(qe_r) * 41'(divisor) + 41'(divisor);
  assign qbit      = ({9'd0, dvd_r} >= next_mult);
  assign quo       = qe_r + 32'(qbit);

  // Results of the shift-add multiplier.
  logic        mul_done;
  logic [63:0] acc_step;
  logic [31:0] x_round;
  logic [31:0] prod_q30;

  assign mul_done = (mul_b_r == '0);
  assign acc_step = mul_b_r[0] ? (acc_r + mul_a_r) : acc_r;
  assign x_round  = 32'((acc_r + 64'h80_0000) >> 24);
  assign prod_q30 = acc_r[61:30];

  // Quadrant mapping of the rounded results.
  logic signed [TW-1:0] s_rnd;
  logic signed [TW-1:0] c_rnd;

  assign s_rnd = to_trig(ssum_r);
  assign c_rnd = to_trig(csum_r);

  // Control of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            state_r <= ST_REDUCE;
          end
        end
        ST_REDUCE: state_r <= ST_XMUL;
        ST_XMUL: begin
          if (mul_done) begin
            state_r <= ST_X2MUL;
          end
        end
        ST_X2MUL: begin
          if (mul_done) begin
            state_r <= ST_SMUL;
          end
        end
        ST_SMUL: begin
          if (mul_done) begin
            state_r <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (mul_done) begin
            state_r <= ST_SFIX;
          end
        end
        ST_SFIX: state_r <= ST_CMUL;
        ST_CMUL: begin
          if (mul_done) begin
            state_r <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (mul_done) begin
            state_r <= ST_CFIX;
          end
        end
        ST_CFIX: begin
          state_r <= (k_r == 4'(SERIES_TERMS)) ? ST_FIN : ST_SMUL;
        end
        ST_FIN: begin
          state_r <= ST_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          ang_r <= req.angle;
        end
      end
      ST_REDUCE: begin
        quad_r  <= quad;
        mul_a_r <= 64'(DEG_TO_RAD_Q);
        mul_b_r <= 32'(frac);
        acc_r   <= '0;
      end
      ST_XMUL, ST_X2MUL, ST_SMUL, ST_SDIV, ST_CMUL, ST_CDIV: begin
        if (!mul_done) begin
          acc_r   <= acc_step;
          mul_a_r <= {mul_a_r[62:0], 1'b0};
          mul_b_r <= {1'b0, mul_b_r[31:1]};
        end else if (state_r == ST_XMUL) begin
          // Radians in Q30, then its square.
          mul_a_r <= 64'(x_round);
          mul_b_r <= x_round;
          acc_r   <= '0;
          st_r    <= x_round;
          ssum_r  <= 34'(x_round);
        end else if (state_r == ST_X2MUL) begin
          x2_r    <= prod_q30;
          ct_r    <= ONE_Q30;
          csum_r  <= 34'(ONE_Q30);
          k_r     <= 4'd1;
          mul_a_r <= 64'(st_r);
          mul_b_r <= prod_q30;
          acc_r   <= '0;
        end else if (state_r == ST_SMUL || state_r == ST_CMUL) begin
          // Divide by the series divisor as a multiply by its reciprocal.
          dvd_r   <= prod_q30;
          mul_a_r <= 64'(prod_q30);
          mul_b_r <= (state_r == ST_SMUL) ? rcp_sin(k_r) : rcp_cos(k_r);
          acc_r   <= '0;
        end else begin
          qe_r <= acc_r[63:32];
        end
      end
      ST_SFIX: begin
        st_r    <= quo;
        ssum_r  <= k_r[0] ? (ssum_r - 34'(quo)) : (ssum_r + 34'(quo));
        mul_a_r <= 64'(ct_r);
        mul_b_r <= x2_r;
        acc_r   <= '0;
      end
      ST_CFIX: begin
        ct_r    <= quo;
        csum_r  <= k_r[0] ? (csum_r - 34'(quo)) : (csum_r + 34'(quo));
        k_r     <= k_r + 4'd1;
        mul_a_r <= 64'(st_r);
        mul_b_r <= x2_r;
        acc_r   <= '0;
      end
      ST_FIN: begin
        case (quad_r)
          2'd0: begin
            sin_o <= s_rnd;
            cos_o <= c_rnd;
          end
          2'd1: begin
            sin_o <= c_rnd;
            cos_o <= -s_rnd;
          end
          2'd2: begin
            sin_o <= -s_rnd;
            cos_o <= -c_rnd;
          end
          default: begin
            sin_o <= -c_rnd;
            cos_o <= s_rnd;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== hdl/cau_pipe.sv =====
// Five-stage pipeline from ground velocity to saturated Coriolis acceleration.
`default_nettype none
module cau_pipe import cau_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  cau_in_if.sink                               in_chan,
  cau_out_if.source                            out_chan,
  input  logic                                 hold,
  input  logic                                 enable,
  input  logic signed [TRIG_FRACTION_BITS+1:0] sin_lat,
  input  logic signed [TRIG_FRACTION_BITS+1:0] cos_lat,
  input  logic signed [TRIG_FRACTION_BITS+1:0] sin_az,
  input  logic signed [TRIG_FRACTION_BITS+1:0] cos_az
);

  localparam int TF  = TRIG_FRACTION_BITS;
  localparam int TW  = TF + 2;
  localparam int EW  = 30;
  localparam int XW  = 31;
  localparam int S1W = VEL_W + TW + 1;
  localparam int S2W = EW + TW + 1;
  localparam int PW  = XW + 34;
  localparam int SH  = VELOCITY_FRACTION_BITS + 12;
  localparam int SHW = PW + 1 - SH;

  localparam logic signed [S1W-1:0] RND1 = S1W'(1) << (TF - 1);
  localparam logic signed [S2W-1:0] RND2 = S2W'(1) << (TF - 1);
  localparam logic signed [PW:0]    RND5 = (PW+1)'(1) << (SH - 1);
  localparam logic signed [SHW-1:0] SAT_HI = SHW'(2147483647);
  localparam logic signed [SHW-1:0] SAT_LO = ~SAT_HI;

  // Per-stage valid bits and ready chain.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic take;

  assign rdy5 = !v5_r || out_chan.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = rdy1 && !hold;
  assign take = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= take;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: rotate by azimuth into east and north. Disabled items enter as zero.
  logic signed [VEL_W-1:0] vd, vu, vc;
  logic signed [S1W-1:0]   s_e, s_n;
  logic signed [EW-1:0]    e1_r, n1_r;
  logic signed [VEL_W-1:0] vu1_r;

  assign vd  = enable ? in_chan.vel_downrange : '0;
  assign vu  = enable ? in_chan.vel_up : '0;
  assign vc  = enable ? in_chan.vel_cross : '0;
  assign s_e = vd * sin_az + vc * cos_az + RND1;
  assign s_n = vd * cos_az - vc * sin_az + RND1;

  always_ff @(posedge clk) begin
    if (rdy1 && take) begin
      e1_r  <= s_e[TF +: EW];
      n1_r  <= s_n[TF +: EW];
      vu1_r <= vu;
    end
  end

  // Stage 2: cross product with the rotation vector at the site latitude.
  logic signed [S2W-1:0] s_ee, s_nn, s_uu;
  logic signed [EW-1:0]  ee2_r, nn2_r, uu2_r;

  assign s_ee = sin_lat * n1_r - cos_lat * vu1_r + RND2;
  assign s_nn = RND2 - sin_lat * e1_r;
  assign s_uu = cos_lat * e1_r + RND2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      ee2_r <= s_ee[TF +: EW];
      nn2_r <= s_nn[TF +: EW];
      uu2_r <= s_uu[TF +: EW];
    end
  end

  // Stage 3: rotate back into the shot frame.
  logic signed [S2W-1:0] s_x, s_z;
  logic signed [XW-1:0]  x3_r, z3_r, u3_r;

  assign s_x = ee2_r * sin_az + nn2_r * cos_az + RND2;
  assign s_z = ee2_r * cos_az - nn2_r * sin_az + RND2;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x3_r <= s_x[TF +: XW];
      z3_r <= s_z[TF +: XW];
      u3_r <= XW'(uu2_r);
    end
  end

  // Stage 4: scale by twice Earth's rotation rate.
  logic signed [PW-1:0] px4_r, pu4_r, pz4_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      px4_r <= x3_r * TWO_OMEGA_Q;
      pu4_r <= u3_r * TWO_OMEGA_Q;
      pz4_r <= z3_r * TWO_OMEGA_Q;
    end
  end

  // Stage 5: round to the output format and saturate.
  function automatic logic signed [ACC_W-1:0] finish(input logic signed [PW-1:0] p);
    logic signed [PW:0]    r;
    logic signed [SHW-1:0] q;
    r = p + RND5;
    q = r[PW:SH];
    if (q > SAT_HI) begin
      finish = SAT_HI[ACC_W-1:0];
    end else if (q < SAT_LO) begin
      finish = SAT_LO[ACC_W-1:0];
    end else begin
      finish = q[ACC_W-1:0];
    end
  endfunction

  logic signed [ACC_W-1:0] ad5_r, au5_r, ac5_r;

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      ad5_r <= finish(px4_r);
      au5_r <= finish(pu4_r);
      ac5_r <= finish(pz4_r);
    end
  end

  assign out_chan.valid         = v5_r;
  assign out_chan.acc_downrange = ad5_r;
  assign out_chan.acc_up        = au5_r;
  assign out_chan.acc_cross     = ac5_r;

endmodule
`default_nettype wire

// ===== hdl/coriolis_acceleration_unit.sv =====
// Coriolis acceleration unit: one velocity transaction in, one acceleration transaction out.
// One transaction per cycle, unless out_chan.ready or the sequencer's hold stalls it.
// A write to latitude or azimuth starts the sine and cosine sequencer, which uses a serial
// multiplier and reciprocal division over ten series terms; while it runs cfg_chan.ready
// is low, and in_chan.ready is also held low while its results are stored. Synchronous
// reset clears the pipeline, disables the unit and sets both angles to zero (sine 0, cosine 1).
`default_nettype none
module coriolis_acceleration_unit import cau_pkg::*; #(
  parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_chan,
  cau_out_if.source out_chan,
  cau_cfg_if.sink   cfg_chan
);

  localparam int TW = TRIG_FRACTION_BITS + 2;
  localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRACTION_BITS;

  trig_req_t           req;
  trig_stat_t          stat;
  logic signed [TW-1:0] trig_sin, trig_cos;
  logic                enable_r;
  logic                tgt_az_r;
  logic signed [TW-1:0] sl_r, cl_r, sa_r, ca_r;
  logic                cfg_take;

  // Configuration transactions are held off while the sequencer runs.
  assign cfg_chan.ready = !stat.busy;
  assign cfg_take = cfg_chan.valid && cfg_chan.ready;

  assign req.start = cfg_take &&
                     (cfg_chan.index == REG_LATITUDE || cfg_chan.index == REG_AZIMUTH);
  assign req.angle = (cfg_chan.index == REG_LATITUDE) ?
                     {{(ANG_W-LAT_W){cfg_chan.data[LAT_W-1]}}, cfg_chan.data[LAT_W-1:0]} :
                     {{(ANG_W-AZ_W){1'b0}}, cfg_chan.data[AZ_W-1:0]};

  // Register file and stored sines and cosines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      tgt_az_r <= 1'b0;
      sl_r     <= '0;
      cl_r     <= TRIG_ONE;
      sa_r     <= '0;
      ca_r     <= TRIG_ONE;
    end else begin
      if (cfg_take && cfg_chan.index == REG_ENABLE) begin
        enable_r <= cfg_chan.data[0];
      end
      if (req.start) begin
        tgt_az_r <= (cfg_chan.index == REG_AZIMUTH);
      end
      if (stat.done) begin
        if (tgt_az_r) begin
          sa_r <= trig_sin;
          ca_r <= trig_cos;
        end else begin
          sl_r <= trig_sin;
          cl_r <= trig_cos;
        end
      end
    end
  end

  cau_trig #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .stat  (stat),
    .sin_o (trig_sin),
    .cos_o (trig_cos)
  );

  // Input is also held while the new sine and cosine are being stored.
  cau_pipe #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .hold     (stat.busy || stat.done),
    .enable   (enable_r),
    .sin_lat  (sl_r),
    .cos_lat  (cl_r),
    .sin_az   (sa_r),
    .cos_az   (ca_r)
  );

endmodule
`default_nettype wire
